// ===== sv/htser_pkg.sv =====
package htser_pkg;

	localparam int DEF_MAX_TABLE_BYTES = 4096;
	localparam int DEF_ENTRY_SLOTS     = 128;
	localparam int ENTRY_OVERHEAD      = 32;
	localparam int LEN_W               = 16;
	localparam int COST_W              = 18;
	localparam int IDX_W               = 32;
	localparam int BYTES_OUT_W         = 13;
	localparam int ENTRIES_OUT_W       = 8;
	localparam int S_TDATA_W           = 96;
	localparam int M_TDATA_W           = 152;

	localparam logic [1:0] FN_INSERT  = 2'd0;
	localparam logic [1:0] FN_SET_CAP = 2'd1;
	localparam logic [1:0] FN_GET     = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_EVLOOP,
		ST_EVSUB,
		ST_WRITE,
		ST_GETCHK,
		ST_GETRD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic set_cap;
		logic clear;
		logic rd_en;
		logic rd_slot;
		logic evict;
		logic write;
		logic calc_off;
		logic get_hit;
		logic get_miss;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       oversize;
		logic       cap_zero;
		logic       need_evict;
		logic       off_in;
		logic       out_free;
	} stat_t;

endpackage

// ===== sv/htser_ctrl.sv =====
module htser_ctrl
	import htser_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				case (stat.func)
					FN_INSERT: begin
						if (stat.oversize) begin
							cmd.clear = 1'b1;
							state_d   = ST_DONE;
						end else begin
							state_d = ST_EVLOOP;
						end
					end
					FN_SET_CAP: begin
						cmd.set_cap = 1'b1;
						if (stat.cap_zero) begin
							cmd.clear = 1'b1;
							state_d   = ST_DONE;
						end else begin
							state_d = ST_EVLOOP;
						end
					end
					FN_GET: begin
						cmd.calc_off = 1'b1;
						state_d      = ST_GETCHK;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_EVLOOP: begin
				if (stat.need_evict) begin
					cmd.rd_en = 1'b1;
					state_d   = ST_EVSUB;
				end else if (stat.func == FN_INSERT) begin
					state_d = ST_WRITE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_EVSUB: begin
				cmd.evict = 1'b1;
				state_d   = ST_EVLOOP;
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_d   = ST_DONE;
			end
			ST_GETCHK: begin
				if (stat.off_in) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_slot = 1'b1;
					state_d     = ST_GETRD;
				end else begin
					cmd.get_miss = 1'b1;
					state_d      = ST_DONE;
				end
			end
			ST_GETRD: begin
				cmd.get_hit = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/htser_dp.sv =====
module htser_dp
	import htser_pkg::*;
#(
	parameter int MAX_TABLE_BYTES = DEF_MAX_TABLE_BYTES,
	parameter int ENTRY_SLOTS     = DEF_ENTRY_SLOTS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	input  logic [1:0]             in_func,
	input  logic [LEN_W-1:0]       in_name_len,
	input  logic [LEN_W-1:0]       in_value_len,
	input  logic [IDX_W-1:0]       in_new_capacity,
	input  logic [IDX_W-1:0]       in_lookup_index,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic                   out_status,
	output logic [M_TDATA_W-1:0]   out_data
);

	localparam int UW = $clog2(MAX_TABLE_BYTES + 1);
	localparam int EW = ((UW > COST_W) ? UW : COST_W) + 1;
	localparam int LW = $clog2(ENTRY_SLOTS + 1);
	localparam int AW = $clog2(ENTRY_SLOTS);
	localparam int SW = LW + 1;

	logic [2*LEN_W-1:0] mem [ENTRY_SLOTS];
	logic [2*LEN_W-1:0] rd_q;

	logic [1:0]        func_q;
	logic [LEN_W-1:0]  name_q;
	logic [LEN_W-1:0]  value_q;
	logic [COST_W-1:0] cost_q;
	logic [UW-1:0]     ncap_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  off_q;

	logic [AW-1:0]     oldest_q;
	logic [AW-1:0]     next_q;
	logic [LW-1:0]     live_q;
	logic [UW-1:0]     used_q;
	logic [UW-1:0]     cap_q;
	logic [IDX_W-1:0]  ins_q;
	logic [IDX_W-1:0]  drop_q;

	logic              status_q;
	logic [IDX_W-1:0]  assigned_q;
	logic [LEN_W-1:0]  fname_q;
	logic [LEN_W-1:0]  fvalue_q;

	logic              out_valid_q;
	logic              out_status_q;
	logic [M_TDATA_W-1:0] out_data_q;

	logic [COST_W-1:0] in_cost;
	logic [UW-1:0]     in_cap;
	logic [EW-1:0]     add_ext;
	logic              size_over;
	logic              slots_full;
	logic [SW-1:0]     slot_sum;
	logic [AW-1:0]     get_slot;
	logic [AW-1:0]     rd_addr;
	logic [COST_W-1:0] ev_cost;
	logic [AW-1:0]     oldest_inc;
	logic [AW-1:0]     next_inc;
	logic [31:0]       used_ext;
	logic [31:0]       live_ext;

	assign in_cost = COST_W'(in_name_len) + COST_W'(in_value_len)
		+ COST_W'(ENTRY_OVERHEAD);
	assign in_cap  = (in_new_capacity > IDX_W'(MAX_TABLE_BYTES)) ?
		UW'(MAX_TABLE_BYTES) : UW'(in_new_capacity);

	assign add_ext    = (func_q == FN_INSERT) ? EW'(cost_q) : '0;
	assign size_over  = (EW'(used_q) + add_ext) > EW'(cap_q);
	assign slots_full = (func_q == FN_INSERT) && (live_q == LW'(ENTRY_SLOTS));

	assign slot_sum = SW'(oldest_q) + SW'(off_q[LW-1:0]);
	assign get_slot = (slot_sum >= SW'(ENTRY_SLOTS)) ?
		AW'(slot_sum - SW'(ENTRY_SLOTS)) : AW'(slot_sum);
	assign rd_addr  = cmd.rd_slot ? get_slot : oldest_q;

	assign ev_cost    = COST_W'(rd_q[LEN_W-1:0]) + COST_W'(rd_q[2*LEN_W-1:LEN_W])
		+ COST_W'(ENTRY_OVERHEAD);
	assign oldest_inc = (oldest_q == AW'(ENTRY_SLOTS - 1)) ? '0 : oldest_q + 1'b1;
	assign next_inc   = (next_q == AW'(ENTRY_SLOTS - 1)) ? '0 : next_q + 1'b1;

	assign stat.func       = func_q;
	assign stat.oversize   = EW'(cost_q) > EW'(cap_q);
	assign stat.cap_zero   = (ncap_q == '0);
	assign stat.need_evict = (live_q != '0) && (size_over || slots_full);
	assign stat.off_in     = off_q < IDX_W'(live_q);
	assign stat.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[next_q] <= {value_q, name_q};
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= in_func;
			name_q  <= in_name_len;
			value_q <= in_value_len;
			cost_q  <= in_cost;
			ncap_q  <= in_cap;
			idx_q   <= in_lookup_index;
		end
		if (cmd.calc_off) begin
			off_q <= idx_q - drop_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q   <= 1'b0;
			assigned_q <= '0;
			fname_q    <= '0;
			fvalue_q   <= '0;
		end else begin
			if (cmd.get_miss) begin
				status_q <= 1'b1;
			end
			if (cmd.get_hit) begin
				fname_q  <= rd_q[LEN_W-1:0];
				fvalue_q <= rd_q[2*LEN_W-1:LEN_W];
			end
			if (cmd.write) begin
				assigned_q <= ins_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			next_q   <= '0;
			live_q   <= '0;
			used_q   <= '0;
			cap_q    <= '0;
			ins_q    <= '0;
			drop_q   <= '0;
		end else begin
			if (cmd.set_cap) begin
				cap_q <= ncap_q;
			end
			if (cmd.clear) begin
				drop_q   <= drop_q + IDX_W'(live_q);
				oldest_q <= '0;
				next_q   <= '0;
				live_q   <= '0;
				used_q   <= '0;
			end else if (cmd.evict) begin
				used_q   <= (EW'(ev_cost) > EW'(used_q)) ? '0 : UW'(EW'(used_q) - EW'(ev_cost));
				oldest_q <= oldest_inc;
				live_q   <= live_q - 1'b1;
				drop_q   <= drop_q + 1'b1;
			end else if (cmd.write) begin
				next_q <= next_inc;
				live_q <= live_q + 1'b1;
				used_q <= UW'(EW'(used_q) + EW'(cost_q));
				ins_q  <= ins_q + 1'b1;
			end
		end
	end

	assign used_ext = 32'(used_q);
	assign live_ext = 32'(live_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_data_q   <= {3'b000, drop_q, ins_q, live_ext[ENTRIES_OUT_W-1:0],
				used_ext[BYTES_OUT_W-1:0], fvalue_q, fname_q, assigned_q};
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_data   = out_data_q;

endmodule

// ===== sv/header_table_size_evict_ring_unit.sv =====
// Size-accounted ring of header-table entries. Each entry costs name length
// plus value length plus 32 bytes; insert evicts oldest entries until the new
// one fits (an entry larger than the capacity clears the table instead),
// set-capacity clamps to MAX_TABLE_BYTES and evicts down, get looks up an
// absolute index. One result per transfer. A zero capacity clears the table
// and unused codes leave the table unchanged. Each evicted entry takes one
// read of the entry store and one update of the size. A full output register
// holds the controller in its done state. Only one item is worked at a time.
module header_table_size_evict_ring_unit
	import htser_pkg::*;
#(
	parameter int MAX_TABLE_BYTES = DEF_MAX_TABLE_BYTES,
	parameter int ENTRY_SLOTS     = DEF_ENTRY_SLOTS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// name_len, value_len, new_capacity, lookup_index
	input  logic [S_TDATA_W-1:0] s_tdata,
	// func
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// assigned_index, found_name_len, found_value_len, bytes_used,
	// entries_held, inserted_total, evicted_total, zero pad
	output logic [M_TDATA_W-1:0] m_tdata,
	// status
	output logic                 m_tuser
);

	cmd_t  cmd;
	stat_t stat;

	htser_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	htser_dp #(
		.MAX_TABLE_BYTES (MAX_TABLE_BYTES),
		.ENTRY_SLOTS     (ENTRY_SLOTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_func         (s_tuser),
		.in_name_len     (s_tdata[15:0]),
		.in_value_len    (s_tdata[31:16]),
		.in_new_capacity (s_tdata[63:32]),
		.in_lookup_index (s_tdata[95:64]),
		.out_ready       (m_tready),
		.out_valid       (m_tvalid),
		.out_status      (m_tuser),
		.out_data        (m_tdata)
	);

endmodule
